### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hdl/tlpa_pkg.sv
package tlpa_pkg;

  localparam int PAGES_DEF = 64;
  localparam int MAX_RES   = 64;

  localparam logic [6:0] LIMIT_RST = 7'd44;
  localparam logic [6:0] MOVE_RST  = 7'd12;

  // Register word index taken from paddr[2].
  localparam logic REG_ACTIVE_LIMIT = 1'b0;
  localparam logic REG_MOVE_COUNT   = 1'b1;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_SCAN   = 1'b1;

  typedef struct packed {
    logic [6:0] active_limit;
    logic [6:0] move_count;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [5:0] page_id;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  page_id_res;
    logic [15:0] hit_count;
    logic [6:0]  active_size;
    logic [6:0]  moved;
    logic        none_referenced;
    logic        last;
  } res_word_t;

endpackage

### hdl/tlpa_if.sv
interface tlpa_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [5:0] page_id;

  modport source (output valid, output command, output page_id, input ready);
  modport sink (input valid, input command, input page_id, output ready);
endinterface

interface tlpa_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  page_id_res;
  logic [15:0] hit_count;
  logic [6:0]  active_size;
  logic [6:0]  moved;
  logic        none_referenced;
  logic        last;

  modport source (output valid, output page_id_res, output hit_count, output active_size,
                  output moved, output none_referenced, output last, input ready);
  modport sink (input valid, input page_id_res, input hit_count, input active_size,
                input moved, input none_referenced, input last, output ready);
endinterface

### hdl/tlpa_regs.sv
module tlpa_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output logic [31:0]   prdata_o,
  output logic          pready_o,
  output tlpa_pkg::cfg_t cfg_o
);
  import tlpa_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr_i[2])
        REG_ACTIVE_LIMIT: cfg_d.active_limit = pwdata_i[6:0];
        REG_MOVE_COUNT:   cfg_d.move_count   = pwdata_i[6:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      REG_ACTIVE_LIMIT: prdata_o = {25'd0, cfg_q.active_limit};
      REG_MOVE_COUNT:   prdata_o = {25'd0, cfg_q.move_count};
      default:          prdata_o = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_limit <= LIMIT_RST;
      cfg_q.move_count   <= MOVE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/tlpa_core.sv
module tlpa_core #(
  parameter int PAGES = tlpa_pkg::PAGES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlpa_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tlpa_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tlpa_pkg::res_word_t out_word_o
);
  import tlpa_pkg::*;

  localparam int IW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int LW = $clog2(PAGES + 1);
  localparam int CW = LW + 8;
  localparam logic [LW-1:0] NIL = LW'(PAGES);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_INIT     = 11'b00000000010,
    ST_WALK     = 11'b00000000100,
    ST_APP_NIL  = 11'b00000001000,
    ST_APP_LINK = 11'b00000010000,
    ST_DEM_CHK  = 11'b00000100000,
    ST_DEM_RD   = 11'b00001000000,
    ST_DEM_UPD  = 11'b00010000000,
    ST_RESULT   = 11'b00100000000,
    ST_SCAN     = 11'b01000000000,
    ST_SCAN_END = 11'b10000000000
  } state_e;

  function automatic logic is_nil(input logic [LW-1:0] v);
    return v >= NIL;
  endfunction

  function automatic logic [IW-1:0] idx(input logic [LW-1:0] v);
    return (v < NIL) ? IW'(v) : '0;
  endfunction

  // Link and hit count stores, one shared read address.
  logic [LW-1:0] link_mem [PAGES];
  logic [15:0]   hit_mem  [PAGES];
  logic [LW-1:0] link_rd_q;
  logic [15:0]   hit_rd_q;
  logic [IW-1:0] rd_addr, lk_wa, hit_wa;
  logic [LW-1:0] lk_wd;
  logic [15:0]   hit_wd, hit_inc;
  logic          lk_we, hit_we;

  state_e        state_q, state_d;
  logic [LW-1:0] cur_q, cur_d, prev_q, prev_d, guard_q, guard_d, init_q, init_d;
  logic [LW-1:0] ah_q, ah_d, at_q, at_d, ih_q, ih_d, it_q, it_d, total_q, total_d;
  logic [5:0]    pg_q, pg_d;
  logic          from_act_q, from_act_d;
  logic [6:0]    mv_q, mv_d, n_q, n_d;
  logic [PAGES-1:0] in_act_q, in_act_d, ref_q, ref_d;
  logic          pend_valid_q, pend_valid_d, out_valid_q, out_valid_d;
  res_word_t     pend_q, pend_d, out_q, out_d;
  logic          out_free;
  logic [LW-1:0] pg_link, in_cur;

  always_ff @(posedge clk_i) begin
    if (lk_we) link_mem[lk_wa] <= lk_wd;
    link_rd_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (hit_we) hit_mem[hit_wa] <= hit_wd;
    hit_rd_q <= hit_mem[rd_addr];
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign hit_inc    = (hit_rd_q == 16'hFFFF) ? hit_rd_q : hit_rd_q + 16'd1;
  assign pg_link    = LW'(pg_q);
  assign in_cur     = in_act_q[IW'(in_word_i.page_id)] ? ah_q : ih_q;

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    guard_d      = guard_q;
    init_d       = init_q;
    ah_d         = ah_q;
    at_d         = at_q;
    ih_d         = ih_q;
    it_d         = it_q;
    total_d      = total_q;
    pg_d         = pg_q;
    from_act_d   = from_act_q;
    mv_d         = mv_q;
    n_d          = n_q;
    in_act_d     = in_act_q;
    ref_d        = ref_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    rd_addr      = idx(cur_q);
    lk_we        = 1'b0;
    lk_wa        = idx(cur_q);
    lk_wd        = NIL;
    hit_we       = 1'b0;
    hit_wa       = idx(cur_q);
    hit_wd       = hit_inc;

    unique case (state_q)
      ST_INIT: begin
        lk_we  = 1'b1;
        lk_wa  = idx(init_q);
        lk_wd  = init_q + LW'(1);
        hit_we = 1'b1;
        hit_wa = idx(init_q);
        hit_wd = 16'd0;
        init_d = init_q + LW'(1);
        if (init_q == NIL - LW'(1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          pg_d    = in_word_i.page_id;
          guard_d = '0;
          prev_d  = NIL;
          mv_d    = '0;
          n_d     = '0;
          if (in_word_i.command == CMD_SCAN) begin
            cur_d   = ah_q;
            rd_addr = idx(ah_q);
            state_d = ST_SCAN;
          end else if (CW'(in_word_i.page_id) < CW'(PAGES)) begin
            from_act_d = in_act_q[IW'(in_word_i.page_id)];
            cur_d      = in_cur;
            rd_addr    = idx(in_cur);
            state_d    = ST_WALK;
          end else begin
            state_d = ST_DEM_CHK;
          end
        end
      end
      ST_WALK: begin
        if (is_nil(cur_q) || guard_q == NIL) begin
          state_d = ST_DEM_CHK;
        end else if (CW'(cur_q) == CW'(pg_q)) begin
          // Splice the page out of its list.
          if (!is_nil(prev_q)) begin
            lk_we = 1'b1;
            lk_wa = idx(prev_q);
            lk_wd = link_rd_q;
          end
          if (from_act_q) begin
            if (is_nil(prev_q)) ah_d = link_rd_q;
            if (at_q == cur_q) at_d = prev_q;
            if (total_q != '0) total_d = total_q - LW'(1);
          end else begin
            if (is_nil(prev_q)) ih_d = link_rd_q;
            if (it_q == cur_q) it_d = prev_q;
          end
          state_d = ST_APP_NIL;
        end else begin
          prev_d  = cur_q;
          cur_d   = link_rd_q;
          guard_d = guard_q + LW'(1);
          rd_addr = idx(link_rd_q);
        end
      end
      ST_APP_NIL: begin
        lk_we = 1'b1;
        lk_wa = idx(pg_link);
        lk_wd = NIL;
        ref_d[idx(pg_link)]    = 1'b1;
        in_act_d[idx(pg_link)] = 1'b1;
        total_d = total_q + LW'(1);
        if (is_nil(ah_q) || is_nil(at_q)) begin
          ah_d    = pg_link;
          at_d    = pg_link;
          state_d = ST_DEM_CHK;
        end else begin
          state_d = ST_APP_LINK;
        end
      end
      ST_APP_LINK: begin
        lk_we   = 1'b1;
        lk_wa   = idx(at_q);
        lk_wd   = pg_link;
        at_d    = pg_link;
        state_d = ST_DEM_CHK;
      end
      ST_DEM_CHK: begin
        state_d = (CW'(total_q) > CW'(cfg_i.active_limit)) ? ST_DEM_RD : ST_RESULT;
      end
      ST_DEM_RD: begin
        if (mv_q < cfg_i.move_count && !is_nil(ah_q)) begin
          rd_addr = idx(ah_q);
          cur_d   = ah_q;
          in_act_d[idx(ah_q)] = 1'b0;
          if (total_q != '0) total_d = total_q - LW'(1);
          mv_d = mv_q + 7'd1;
          if (is_nil(ih_q) || is_nil(it_q)) begin
            ih_d = ah_q;
          end else begin
            lk_we = 1'b1;
            lk_wa = idx(it_q);
            lk_wd = ah_q;
          end
          it_d    = ah_q;
          state_d = ST_DEM_UPD;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_DEM_UPD: begin
        if (is_nil(link_rd_q)) begin
          ah_d = NIL;
          at_d = NIL;
        end else begin
          ah_d = link_rd_q;
        end
        lk_we   = 1'b1;
        lk_wa   = idx(cur_q);
        lk_wd   = NIL;
        state_d = ST_DEM_RD;
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{page_id_res: pg_q, hit_count: 16'd0, active_size: 7'(total_q),
                          moved: mv_q, none_referenced: 1'b0, last: 1'b1};
          state_d     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (is_nil(cur_q) || guard_q == NIL || n_q == 7'(MAX_RES)) begin
          state_d = ST_SCAN_END;
        end else if (!ref_q[idx(cur_q)] || !pend_valid_q || out_free) begin
          if (ref_q[idx(cur_q)]) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            hit_we              = 1'b1;
            ref_d[idx(cur_q)]   = 1'b0;
            pend_valid_d        = 1'b1;
            pend_d              = '{page_id_res: 6'(cur_q), hit_count: hit_inc,
                                    active_size: 7'(total_q), moved: 7'd0,
                                    none_referenced: 1'b0, last: 1'b0};
            n_d                 = n_q + 7'd1;
          end
          cur_d   = link_rd_q;
          guard_d = guard_q + LW'(1);
          rd_addr = idx(link_rd_q);
        end
      end
      ST_SCAN_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (pend_valid_q) begin
            out_d        = pend_q;
            out_d.last   = 1'b1;
            pend_valid_d = 1'b0;
          end else begin
            out_d = '{page_id_res: 6'd0, hit_count: 16'd0, active_size: 7'(total_q),
                      moved: 7'd0, none_referenced: 1'b1, last: 1'b1};
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      init_q       <= '0;
      ah_q         <= NIL;
      at_q         <= NIL;
      ih_q         <= '0;
      it_q         <= NIL - LW'(1);
      total_q      <= '0;
      in_act_q     <= '0;
      ref_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      ah_q         <= ah_d;
      at_q         <= at_d;
      ih_q         <= ih_d;
      it_q         <= it_d;
      total_q      <= total_d;
      in_act_q     <= in_act_d;
      ref_q        <= ref_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    guard_q    <= guard_d;
    pg_q       <= pg_d;
    from_act_q <= from_act_d;
    mv_q       <= mv_d;
    n_q        <= n_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### hdl/two_list_page_aging.sv
// Two-list page aging: active / inactive LRU lists of PAGES pages.
// Input channel in_if carries one word per command: an access (command 0)
// moves page_id to the active tail and demotes up to move_count pages from
// the active head once the active size passes active_limit; a scan
// (command 1) reports every referenced active page with its new hit count.
// Output channel out_if gives one word per access and one to 64 per scan;
// last marks the final word of a command.
// An access walks the page's list, appends it and demotes; a scan walks the
// active list. The walk over the link memory takes one entry per cycle
// through its single read port, while no stalled output word holds a scan;
// one command is in work at a time.
// Reset empties the active list and clears all bits, then an init sweep writes
// the inactive chain and zero hit counts; in_if.ready stays low meanwhile.
// A stalled receiver holds the output word; a scan then waits on the next
// referenced page, and a new command is taken while the last word waits.
// Registers over APB: 0x0 active_limit, 0x4 move_count (7 bits each).
module two_list_page_aging #(
  parameter int PAGES = tlpa_pkg::PAGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tlpa_in_if.sink     in_if,
  tlpa_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlpa_pkg::*;

  cfg_t      cfg;
  in_word_t  in_word;
  res_word_t res_word;
  logic      in_ready;

  // Pack the incoming word for the engine.
  assign in_word.command = in_if.command;
  assign in_word.page_id = in_if.page_id;
  assign in_if.ready     = in_ready;

  // Unpack the result word onto the output channel.
  assign out_if.page_id_res     = res_word.page_id_res;
  assign out_if.hit_count       = res_word.hit_count;
  assign out_if.active_size     = res_word.active_size;
  assign out_if.moved           = res_word.moved;
  assign out_if.none_referenced = res_word.none_referenced;
  assign out_if.last            = res_word.last;

  tlpa_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  tlpa_core #(.PAGES(PAGES)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_word_o  (res_word)
  );

endmodule

### hdl/tlpa_checker.sv
`include "assert_macros.svh"

module tlpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [5:0]  page_id_res_i,
  input logic [15:0] hit_count_i,
  input logic [6:0]  moved_i,
  input logic        none_referenced_i,
  input logic        last_i
);

  // One command in work: ready drops right after a word is taken.
  `ASSERT_NEXT(a_one_cmd, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // An empty scan is a single, closing, zeroed word.
  `ASSERT_IMPLY(a_empty_scan, clk_i, rst_ni, out_valid_i && none_referenced_i, last_i && hit_count_i == 16'd0 && page_id_res_i == 6'd0)
  // Scan hits never report demotion.
  `ASSERT_IMPLY(a_scan_no_move, clk_i, rst_ni, out_valid_i && hit_count_i != 16'd0, moved_i == 7'd0 && !none_referenced_i)
  // A stalled output word stays valid.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

endmodule

bind two_list_page_aging tlpa_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_if.valid),
  .in_ready_i        (in_if.ready),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .page_id_res_i     (out_if.page_id_res),
  .hit_count_i       (out_if.hit_count),
  .moved_i           (out_if.moved),
  .none_referenced_i (out_if.none_referenced),
  .last_i            (out_if.last)
);
